[rtl/dbbt_pkg.sv]
// Shared types, codes and helpers of the disk block buffer table.
package dbbt_pkg;

    localparam int OP_W     = 3;
    localparam int BLK_W    = 13;
    localparam int TYPE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 5;
    localparam int MAP_W    = 32;
    localparam int MAP_SH   = 5;

    localparam logic [OP_W-1:0] OP_GET     = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_MAP = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WRONG_TYPE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DISK_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd4;

    localparam logic [TYPE_W-1:0] TYPE_RECORD   = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_INTERNAL = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_LEAF     = 2'd2;

    typedef struct packed {
        logic [BLK_W-1:0]  blk;
        logic [TYPE_W-1:0] typ;
    } slot_ent_t;

    function automatic logic [STATUS_W-1:0] type_status(input logic want_index,
                                                         input logic [TYPE_W-1:0] t);
        logic ok;
        if (want_index)
        begin
            ok = (t == TYPE_INTERNAL) || (t == TYPE_LEAF);
        end
        else
        begin
            ok = (t == TYPE_RECORD);
        end
        return ok ? ST_OK : ST_WRONG_TYPE;
    endfunction

endpackage

[rtl/dbbt_req_if.sv]
// Request channel of the disk block buffer table.
interface dbbt_req_if;
    import dbbt_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BLK_W-1:0]  block_id;
    logic              want_index;
    logic [TYPE_W-1:0] new_type;
    logic [TYPE_W-1:0] loaded_type;
    logic              map_value;

    modport source (output valid, operation, block_id, want_index, new_type,
                    loaded_type, map_value, input ready);
    modport sink (input valid, operation, block_id, want_index, new_type,
                  loaded_type, map_value, output ready);
endinterface

[rtl/dbbt_res_if.sv]
// Result channel of the disk block buffer table.
interface dbbt_res_if;
    import dbbt_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [BLK_W-1:0]    block_out;
    logic                hit;
    logic                writeback;
    logic [TYPE_W-1:0]   found_type;

    modport source (output valid, status, slot, block_out, hit, writeback, found_type,
                    input ready);
    modport sink (input valid, status, slot, block_out, hit, writeback, found_type,
                  output ready);
endinterface

[rtl/disk_block_buffer_table_core.sv]
// Buffer slot table with disk allocation map. Get, release and delete scan the slot memory
// one entry per cycle; delete then reads the map word and clears the block's bit. Alloc
// scans the map memory 32 bits per cycle; set map reads the map word and writes the bit.
// After reset a clearing pass zeroes the map before the first transfer is taken. One item
// is in work at a time; a result waits in an output register while the next request is
// taken.
module disk_block_buffer_table_core #(
    parameter int SLOT_COUNT       = 32,
    parameter int DISK_BLOCK_COUNT = 8192,
    parameter int RESERVED_BLOCKS  = 4
) (
    input  logic clk,
    input  logic rst_n,
    dbbt_req_if.sink   req,
    dbbt_res_if.source res
);
    import dbbt_pkg::*;

    localparam int SW        = $clog2(SLOT_COUNT);
    localparam int MAP_WORDS = (DISK_BLOCK_COUNT + MAP_W - 1) / MAP_W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_MAX   = (MAP_WORDS > SLOT_COUNT) ? MAP_WORDS : SLOT_COUNT;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_ASCAN = 3'd3;
    localparam logic [2:0] S_MRD   = 3'd4;
    localparam logic [2:0] S_MWR   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      pidx_reg, pidx_next;
    logic                  pv_reg, pv_next;
    logic [SLOT_COUNT-1:0] used_reg, used_next;
    logic [SLOT_COUNT-1:0] dirty_reg, dirty_next;
    logic                  ov_reg, ov_next;

    logic [OP_W-1:0]     op_reg;
    logic [BLK_W-1:0]    blk_reg;
    logic                want_reg;
    logic [TYPE_W-1:0]   ntype_reg;
    logic [TYPE_W-1:0]   ltype_reg;
    logic                mbit_reg, mbit_next;
    logic                capture;

    logic [STATUS_W-1:0] rst_reg, rst_next;
    logic [SLOT_W-1:0]   rslot_reg, rslot_next;
    logic [BLK_W-1:0]    rblk_reg, rblk_next;
    logic                rhit_reg, rhit_next;
    logic                rwb_reg, rwb_next;
    logic [TYPE_W-1:0]   rtype_reg, rtype_next;

    logic [STATUS_W-1:0] ostatus_reg;
    logic [SLOT_W-1:0]   oslot_reg;
    logic [BLK_W-1:0]    oblk_reg;
    logic                ohit_reg;
    logic                owb_reg;
    logic [TYPE_W-1:0]   otype_reg;
    logic                load_out;

    slot_ent_t slot_mem [SLOT_COUNT];
    slot_ent_t slot_rd_reg;
    logic            slot_we;
    logic [SW-1:0]   slot_wa;
    slot_ent_t       slot_wd;
    logic [SW-1:0]   slot_ra;

    logic             map_we;
    logic [AW-1:0]    map_wa;
    logic [MAP_W-1:0] map_wd;
    logic [AW-1:0]    map_ra;
    logic [MAP_W-1:0] map_rd;

    logic          free_any;
    logic [SW-1:0] free_idx;
    logic [SW-1:0] pslot;
    logic          slot_match;
    logic          slot_last;
    logic [AW-1:0] pword;
    logic [MAP_W-1:0] taken;
    logic          zero_any;
    logic [MAP_SH-1:0] zero_pos;
    logic [31:0]   found_blk;
    logic          word_last;
    logic [AW-1:0] blk_word;

    dbbt_map_ram #(.WORDS(MAP_WORDS), .AW(AW)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_wa),
        .wdata (map_wd),
        .raddr (map_ra),
        .rdata (map_rd)
    );

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd_reg <= slot_mem[slot_ra];
    end

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    assign pslot      = pidx_reg[SW-1:0];
    assign slot_match = pv_reg && used_reg[pslot] && (slot_rd_reg.blk == blk_reg);
    assign slot_last  = pv_reg && (pslot == SW'(SLOT_COUNT - 1));
    assign pword      = pidx_reg[AW-1:0];
    assign word_last  = pv_reg && (pword == AW'(MAP_WORDS - 1));
    assign blk_word   = AW'(blk_reg >> MAP_SH);

    always_comb
    begin
        for (int j = 0; j < MAP_W; j++)
        begin
            taken[j] = map_rd[j]
                     || (((32'(pword) << MAP_SH) + 32'(j)) < 32'(RESERVED_BLOCKS))
                     || (((32'(pword) << MAP_SH) + 32'(j)) >= 32'(DISK_BLOCK_COUNT));
        end
        zero_any = 1'b0;
        zero_pos = '0;
        for (int j = MAP_W - 1; j >= 0; j--)
        begin
            if (!taken[j])
            begin
                zero_any = 1'b1;
                zero_pos = MAP_SH'(j);
            end
        end
        found_blk = (32'(pword) << MAP_SH) | 32'(zero_pos);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pidx_next  = pidx_reg;
        pv_next    = 1'b0;
        used_next  = used_reg;
        dirty_next = dirty_reg;
        mbit_next  = mbit_reg;
        capture    = 1'b0;
        load_out   = 1'b0;
        rst_next   = rst_reg;
        rslot_next = rslot_reg;
        rblk_next  = rblk_reg;
        rhit_next  = rhit_reg;
        rwb_next   = rwb_reg;
        rtype_next = rtype_reg;
        slot_we    = 1'b0;
        slot_wa    = free_idx;
        slot_wd    = '{blk: blk_reg, typ: ltype_reg};
        slot_ra    = cnt_reg[SW-1:0];
        map_we     = 1'b0;
        map_wa     = blk_word;
        map_wd     = map_rd;
        map_ra     = cnt_reg[AW-1:0];

        unique case (state_reg)
            S_CLR:
            begin
                map_we = 1'b1;
                map_wa = cnt_reg[AW-1:0];
                map_wd = '0;
                if (cnt_reg == CNT_W'(MAP_WORDS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    capture    = 1'b1;
                    cnt_next   = '0;
                    rst_next   = ST_OK;
                    rslot_next = '0;
                    rblk_next  = req.block_id;
                    rhit_next  = 1'b0;
                    rwb_next   = 1'b0;
                    rtype_next = '0;
                    mbit_next  = req.map_value;
                    if (req.operation == OP_ALLOC)
                    begin
                        state_next = S_ASCAN;
                    end
                    else if (req.operation > OP_SET_MAP
                             || 32'(req.block_id) >= 32'(DISK_BLOCK_COUNT))
                    begin
                        rst_next   = ST_RANGE;
                        state_next = S_OUT;
                    end
                    else if (req.operation == OP_SET_MAP)
                    begin
                        state_next = S_MRD;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (cnt_reg < CNT_W'(SLOT_COUNT))
                begin
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg;
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (slot_match)
                begin
                    rslot_next = SLOT_W'(pslot);
                    rtype_next = slot_rd_reg.typ;
                    rhit_next  = 1'b1;
                    if (op_reg == OP_GET)
                    begin
                        rst_next   = type_status(want_reg, slot_rd_reg.typ);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        rwb_next          = (op_reg == OP_RELEASE) && dirty_reg[pslot];
                        used_next[pslot]  = 1'b0;
                        dirty_next[pslot] = 1'b0;
                        mbit_next         = 1'b0;
                        state_next        = (op_reg == OP_DELETE) ? S_MRD : S_OUT;
                    end
                end
                else if (slot_last)
                begin
                    mbit_next  = 1'b0;
                    state_next = (op_reg == OP_DELETE) ? S_MRD : S_OUT;
                    if (op_reg == OP_GET)
                    begin
                        if (free_any)
                        begin
                            slot_we              = 1'b1;
                            used_next[free_idx]  = 1'b1;
                            dirty_next[free_idx] = 1'b0;
                            rslot_next           = SLOT_W'(free_idx);
                            rtype_next           = ltype_reg;
                            rst_next             = type_status(want_reg, ltype_reg);
                        end
                        else
                        begin
                            rst_next = ST_NO_SLOT;
                        end
                    end
                end
            end
            S_ASCAN:
            begin
                if (cnt_reg < CNT_W'(MAP_WORDS))
                begin
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg;
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pv_reg && zero_any)
                begin
                    rblk_next  = BLK_W'(found_blk);
                    state_next = S_OUT;
                    if (free_any)
                    begin
                        slot_we              = 1'b1;
                        slot_wd              = '{blk: BLK_W'(found_blk), typ: ntype_reg};
                        used_next[free_idx]  = 1'b1;
                        dirty_next[free_idx] = 1'b1;
                        rslot_next           = SLOT_W'(free_idx);
                        rtype_next           = ntype_reg;
                        map_we               = 1'b1;
                        map_wa               = pword;
                        map_wd               = map_rd | (MAP_W'(1) << zero_pos);
                    end
                    else
                    begin
                        rst_next = ST_NO_SLOT;
                    end
                end
                else if (word_last)
                begin
                    rst_next   = ST_DISK_FULL;
                    rblk_next  = '0;
                    state_next = S_OUT;
                end
            end
            S_MRD:
            begin
                map_ra     = blk_word;
                state_next = S_MWR;
            end
            S_MWR:
            begin
                map_we                  = 1'b1;
                map_wd[blk_reg[MAP_SH-1:0]] = mbit_reg;
                state_next              = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || res.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ov_next = ov_reg;
        if (res.ready)
        begin
            ov_next = 1'b0;
        end
        if (load_out)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            pidx_reg  <= '0;
            pv_reg    <= 1'b0;
            used_reg  <= '0;
            dirty_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pidx_reg  <= pidx_next;
            pv_reg    <= pv_next;
            used_reg  <= used_next;
            dirty_reg <= dirty_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            op_reg    <= req.operation;
            blk_reg   <= req.block_id;
            want_reg  <= req.want_index;
            ntype_reg <= req.new_type;
            ltype_reg <= req.loaded_type;
        end
        mbit_reg  <= mbit_next;
        rst_reg   <= rst_next;
        rslot_reg <= rslot_next;
        rblk_reg  <= rblk_next;
        rhit_reg  <= rhit_next;
        rwb_reg   <= rwb_next;
        rtype_reg <= rtype_next;
        if (load_out)
        begin
            ostatus_reg <= rst_reg;
            oslot_reg   <= rslot_reg;
            oblk_reg    <= rblk_reg;
            ohit_reg    <= rhit_reg;
            owb_reg     <= rwb_reg;
            otype_reg   <= rtype_reg;
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign res.valid      = ov_reg;
    assign res.status     = ostatus_reg;
    assign res.slot       = oslot_reg;
    assign res.block_out  = oblk_reg;
    assign res.hit        = ohit_reg;
    assign res.writeback  = owb_reg;
    assign res.found_type = otype_reg;

    a_dirty_used: assert property (@(posedge clk) disable iff (!rst_n)
        (dirty_reg & ~used_reg) == '0)
        else $error("Dirty bit set on a free slot.");

    a_wb_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.writeback) |-> res.hit)
        else $error("Write-back reported without a hit.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.status <= ST_RANGE))
        else $error("Result status outside the defined codes.");

    a_slot_freed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && slot_match && op_reg != OP_GET)
            |=> !used_reg[$past(pslot)])
        else $error("Released slot still marked used.");
endmodule

[rtl/dbbt_map_ram.sv]
// Allocation map memory: one write port and one registered read port.
module dbbt_map_ram #(
    parameter int WORDS = 256,
    parameter int AW    = 8
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [dbbt_pkg::MAP_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [dbbt_pkg::MAP_W-1:0] rdata
);
    import dbbt_pkg::*;

    logic [MAP_W-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
